// ----- rtl/csc_pkg.sv -----
// Shared types, constants and the arctangent table for the CORDIC sine/cosine block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package csc_pkg;

    localparam int unsigned ANGLE_W      = 32;   // input angle width
    localparam int unsigned Z_W          = 22;   // residual angle width in the rotation chain
    localparam int unsigned XY_W         = 22;   // vector component width in the rotation chain
    localparam int unsigned OUT_W        = 20;   // sine / cosine width
    localparam int unsigned ATAN_LEN     = 20;   // entries in the arctangent table
    localparam int unsigned ITER_DEFAULT = 20;
    localparam int unsigned MOD_STAGES   = 11;   // quotient bits of |angle| / two_pi

    localparam int unsigned HALF_PI_VAL  = 32'h0006487F;
    localparam int unsigned TWO_PI_VAL   = 4 * HALF_PI_VAL;

    localparam logic signed [Z_W-1:0]  HALF_PI = Z_W'(HALF_PI_VAL);
    localparam logic signed [Z_W-1:0]  PI      = Z_W'(2 * HALF_PI_VAL);
    localparam logic signed [Z_W-1:0]  TWO_PI  = Z_W'(TWO_PI_VAL);
    localparam logic signed [XY_W-1:0] X_START = XY_W'(32'h00026DD3);

    typedef enum logic [1:0] {
        FOLD_NONE = 2'd0,
        FOLD_UP   = 2'd1,
        FOLD_DOWN = 2'd2
    } fold_t;

    // Control word that rides along the angle reduction cells.
    typedef struct packed {
        logic valid;
        logic neg;
    } mod_ctl_t;

    // Control word that rides along the rotation cells.
    typedef struct packed {
        logic  valid;
        fold_t fold;
    } rot_ctl_t;

    function automatic logic signed [Z_W-1:0] atan_value(input int unsigned k);
        logic signed [Z_W-1:0] a;
        unique case (k)
            0:       a = 22'sh03243F;
            1:       a = 22'sh01DAC6;
            2:       a = 22'sh00FADB;
            3:       a = 22'sh007F56;
            4:       a = 22'sh003FEA;
            5:       a = 22'sh001FFD;
            6:       a = 22'sh000FFF;
            7:       a = 22'sh0007FF;
            8:       a = 22'sh0003FF;
            9:       a = 22'sh0001FF;
            10:      a = 22'sh0000FF;
            11:      a = 22'sh00007F;
            12:      a = 22'sh00003F;
            13:      a = 22'sh00001F;
            14:      a = 22'sh00000F;
            15:      a = 22'sh000007;
            16:      a = 22'sh000003;
            17:      a = 22'sh000001;
            default: a = 22'sh000000;
        endcase
        return a;
    endfunction

    // Cycles from an accepted start to the done strobe.
    function automatic int unsigned latency(input int unsigned iterations);
        return 1 + MOD_STAGES + 2 + iterations + 1;
    endfunction

endpackage

// ----- rtl/csc_mod_cell.sv -----
// One restoring-remainder cell of the two_pi angle reduction chain.
// Depends on csc_pkg.
module csc_mod_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csc_pkg::mod_ctl_t              ctl_in,
    input  logic [csc_pkg::ANGLE_W-1:0]    rem_in,
    output csc_pkg::mod_ctl_t              ctl_out,
    output logic [csc_pkg::ANGLE_W-1:0]    rem_out
);

    localparam logic [csc_pkg::ANGLE_W:0] DIVISOR =
        (csc_pkg::ANGLE_W + 1)'(csc_pkg::TWO_PI_VAL) << SHIFT;

    csc_pkg::mod_ctl_t               ctl_reg;
    logic [csc_pkg::ANGLE_W-1:0]     rem_reg;
    logic [csc_pkg::ANGLE_W-1:0]     rem_next;

    // Subtract the shifted divisor when it fits.
    always_comb
    begin
        if ({1'b0, rem_in} >= DIVISOR)
        begin
            rem_next = rem_in - DIVISOR[csc_pkg::ANGLE_W-1:0];
        end
        else
        begin
            rem_next = rem_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;

endmodule

// ----- rtl/csc_rot_cell.sv -----
// One CORDIC rotation-mode micro-rotation cell with a fixed shift and arctangent.
// Depends on csc_pkg.
module csc_rot_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csc_pkg::rot_ctl_t                   ctl_in,
    input  logic signed [csc_pkg::XY_W-1:0]     x_in,
    input  logic signed [csc_pkg::XY_W-1:0]     y_in,
    input  logic signed [csc_pkg::Z_W-1:0]      z_in,
    output csc_pkg::rot_ctl_t                   ctl_out,
    output logic signed [csc_pkg::XY_W-1:0]     x_out,
    output logic signed [csc_pkg::XY_W-1:0]     y_out,
    output logic signed [csc_pkg::Z_W-1:0]      z_out
);

    localparam logic signed [csc_pkg::Z_W-1:0] ATAN = csc_pkg::atan_value(STAGE);

    csc_pkg::rot_ctl_t                   ctl_reg;
    logic signed [csc_pkg::XY_W-1:0]     x_reg;
    logic signed [csc_pkg::XY_W-1:0]     y_reg;
    logic signed [csc_pkg::Z_W-1:0]      z_reg;
    logic signed [csc_pkg::XY_W-1:0]     x_next;
    logic signed [csc_pkg::XY_W-1:0]     y_next;
    logic signed [csc_pkg::Z_W-1:0]      z_next;
    logic signed [csc_pkg::XY_W-1:0]     xs;
    logic signed [csc_pkg::XY_W-1:0]     ys;

    assign xs = x_in >>> STAGE;
    assign ys = y_in >>> STAGE;

    // Rotate toward zero residual angle.
    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ----- rtl/cordic_sin_cos.sv -----
// Top level of the pipelined CORDIC sine/cosine block.
// Depends on csc_pkg, csc_mod_cell and csc_rot_cell.
//
//  channel  | handshake     | payload              | direction
//  ---------+---------------+----------------------+----------
//  command  | start / busy  | angle  (32b signed)  | in
//  result   | done          | sine, cosine (20b s) | out
//
// One word enters per cycle; busy is never raised. Each angle runs through an
// input register, MOD_STAGES remainder cells, a map stage, a fold stage,
// ITERATIONS rotation cells and an output register before done is raised.
// Reset clears only the control words of the chain; no word is in flight afterward.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module cordic_sin_cos #(
    parameter int unsigned ITERATIONS = csc_pkg::ITER_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [csc_pkg::ANGLE_W-1:0]    angle,
    output logic                                  done,
    output logic signed [csc_pkg::OUT_W-1:0]      sine,
    output logic signed [csc_pkg::OUT_W-1:0]      cosine
);

    localparam int unsigned ANGLE_W = csc_pkg::ANGLE_W;
    localparam int unsigned Z_W     = csc_pkg::Z_W;
    localparam int unsigned XY_W    = csc_pkg::XY_W;
    localparam int unsigned OUT_W   = csc_pkg::OUT_W;
    localparam int unsigned NMOD    = csc_pkg::MOD_STAGES;

    localparam logic signed [XY_W:0] SAT_HI = (XY_W + 1)'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [XY_W:0] SAT_LO = -SAT_HI - (XY_W + 1)'(1);

    // Clamp to the output range; the CORDIC result stays well inside it anyway.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [XY_W:0] v);
        logic signed [XY_W:0] c;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else
        begin
            c = v;
        end
        return c[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input register: split the angle into sign and magnitude.
    // ------------------------------------------------------------------
    csc_pkg::mod_ctl_t       in_ctl_reg;
    logic [ANGLE_W-1:0]      in_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else
        begin
            in_ctl_reg.valid <= start;
            in_ctl_reg.neg   <= angle[ANGLE_W-1];
        end
    end

    // Magnitude of the most negative angle is 2^31, which still fits unsigned.
    always_ff @(posedge clk)
    begin
        in_mag_reg <= angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Truncating remainder by two_pi: one quotient bit per cell, MSB first.
    // The sign rides along, so the remainder keeps the sign of the angle.
    // ------------------------------------------------------------------
    csc_pkg::mod_ctl_t  mod_ctl [0:NMOD];
    logic [ANGLE_W-1:0] mod_rem [0:NMOD];

    assign mod_ctl[0] = in_ctl_reg;
    assign mod_rem[0] = in_mag_reg;

    for (genvar i = 0; i < NMOD; i++)
    begin : g_mod
        csc_mod_cell #(
            .SHIFT (NMOD - 1 - i)
        ) u_mod_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (mod_ctl[i]),
            .rem_in  (mod_rem[i]),
            .ctl_out (mod_ctl[i+1]),
            .rem_out (mod_rem[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Map stage: apply the sign and move into -pi..pi (strict compares).
    // The remainder is below two_pi, so it fits in Z_W-1 bits.
    // ------------------------------------------------------------------
    csc_pkg::rot_ctl_t       map_ctl_reg;
    logic signed [Z_W-1:0]   map_theta_reg;
    logic signed [Z_W-1:0]   map_theta_next;
    logic signed [Z_W-1:0]   rem_mag;

    assign rem_mag = {1'b0, mod_rem[NMOD][Z_W-2:0]};

    always_comb
    begin
        if (rem_mag > csc_pkg::PI)
        begin
            map_theta_next = mod_ctl[NMOD].neg ? (csc_pkg::TWO_PI - rem_mag)
                                               : (rem_mag - csc_pkg::TWO_PI);
        end
        else
        begin
            map_theta_next = mod_ctl[NMOD].neg ? -rem_mag : rem_mag;
        end
    end

    // ------------------------------------------------------------------
    // Fold stage: fold into -pi/2..pi/2 and remember which way.
    // ------------------------------------------------------------------
    csc_pkg::rot_ctl_t       fold_ctl_reg;
    logic signed [Z_W-1:0]   fold_z_reg;
    logic signed [Z_W-1:0]   fold_z_next;
    csc_pkg::fold_t          fold_next;

    always_comb
    begin
        priority if (map_theta_reg > csc_pkg::HALF_PI)
        begin
            fold_z_next = map_theta_reg - csc_pkg::HALF_PI;
            fold_next   = csc_pkg::FOLD_UP;
        end
        else if (map_theta_reg < -csc_pkg::HALF_PI)
        begin
            fold_z_next = map_theta_reg + csc_pkg::HALF_PI;
            fold_next   = csc_pkg::FOLD_DOWN;
        end
        else
        begin
            fold_z_next = map_theta_reg;
            fold_next   = csc_pkg::FOLD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_ctl_reg  <= '0;
            fold_ctl_reg <= '0;
        end
        else
        begin
            map_ctl_reg.valid  <= mod_ctl[NMOD].valid;
            map_ctl_reg.fold   <= csc_pkg::FOLD_NONE;
            fold_ctl_reg.valid <= map_ctl_reg.valid;
            fold_ctl_reg.fold  <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        map_theta_reg <= map_theta_next;
        fold_z_reg    <= fold_z_next;
    end

    // ------------------------------------------------------------------
    // Rotation chain: start from the gain-compensated unit on the x axis.
    // The last residual angle is not needed downstream.
    // ------------------------------------------------------------------
    csc_pkg::rot_ctl_t       rot_ctl [0:ITERATIONS];
    logic signed [XY_W-1:0]  rot_x   [0:ITERATIONS];
    logic signed [XY_W-1:0]  rot_y   [0:ITERATIONS];
    logic signed [Z_W-1:0]   rot_z   [0:ITERATIONS];

    assign rot_ctl[0] = fold_ctl_reg;
    assign rot_x[0]   = csc_pkg::X_START;
    assign rot_y[0]   = '0;
    assign rot_z[0]   = fold_z_reg;

    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_rot
        csc_rot_cell #(
            .STAGE (k)
        ) u_rot_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (rot_ctl[k]),
            .x_in    (rot_x[k]),
            .y_in    (rot_y[k]),
            .z_in    (rot_z[k]),
            .ctl_out (rot_ctl[k+1]),
            .x_out   (rot_x[k+1]),
            .y_out   (rot_y[k+1]),
            .z_out   (rot_z[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Quadrant fix-up and output register.
    // ------------------------------------------------------------------
    logic signed [XY_W:0]      x_ext;
    logic signed [XY_W:0]      y_ext;
    logic signed [XY_W:0]      s_wide;
    logic signed [XY_W:0]      c_wide;
    logic                      done_reg;
    logic signed [OUT_W-1:0]   sine_reg;
    logic signed [OUT_W-1:0]   cosine_reg;

    assign x_ext = (XY_W + 1)'(rot_x[ITERATIONS]);
    assign y_ext = (XY_W + 1)'(rot_y[ITERATIONS]);

    always_comb
    begin
        unique case (rot_ctl[ITERATIONS].fold)
            csc_pkg::FOLD_UP:
            begin
                s_wide = x_ext;
                c_wide = -y_ext;
            end
            csc_pkg::FOLD_DOWN:
            begin
                s_wide = -x_ext;
                c_wide = y_ext;
            end
            default:
            begin
                s_wide = y_ext;
                c_wide = x_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rot_ctl[ITERATIONS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= sat_out(s_wide);
        cosine_reg <= sat_out(c_wide);
    end

    assign done   = done_reg;
    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

// ----- rtl/csc_checker.sv -----
// Port-level checker for cordic_sin_cos, attached by the bind at the end of the file.
// Depends on csc_pkg and on the port list of cordic_sin_cos.
module csc_checker #(
    parameter int unsigned ITERATIONS = csc_pkg::ITER_DEFAULT
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic signed [csc_pkg::ANGLE_W-1:0]    angle,
    input logic                                  done,
    input logic signed [csc_pkg::OUT_W-1:0]      sine,
    input logic signed [csc_pkg::OUT_W-1:0]      cosine
);

    localparam int unsigned LAT = csc_pkg::latency(ITERATIONS);

    localparam logic signed [csc_pkg::OUT_W-1:0] MAG_HI = csc_pkg::OUT_W'(270000);
    localparam logic signed [csc_pkg::OUT_W-1:0] MAG_LO = -MAG_HI;

    // Never refuse a word.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every offered word carries a known angle.
    a_angle_known: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !$isunknown(angle))
        else $error("unknown angle offered");

    // Every accepted word yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result lost");

    // No result without a word accepted the latency earlier.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result invented");

    // The rotated vector keeps unit length, so neither output exceeds MAG_HI in magnitude.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sine <= MAG_HI && sine >= MAG_LO && cosine <= MAG_HI
                  && cosine >= MAG_LO))
        else $error("output off the unit circle");

endmodule

bind cordic_sin_cos csc_checker #(
    .ITERATIONS (ITERATIONS)
) u_csc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .angle  (angle),
    .done   (done),
    .sine   (sine),
    .cosine (cosine)
);
